@@ hdl/g2e_pkg.sv @@
// Constants and elaboration-time table builders for the geodetic to ENU converter.
`timescale 1ns / 1ps
package g2e_pkg;

  localparam int unsigned ITER    = 60;
  localparam int unsigned NEWTON  = 8;
  localparam int unsigned MUL_LAT = 3;

  localparam logic signed [63:0] ONE   = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] THREE = 64'sh3000_0000_0000_0000;
  localparam logic signed [32:0] HALF_TURN    = 33'sd1800000000;
  localparam logic signed [32:0] QUARTER_TURN = 33'sd900000000;
  localparam logic signed [63:0] OUT_LIM      = 64'sd20000000000;
  localparam logic signed [63:0] A_Q16        = 64'sd6378137000 * 64'sd65536;
  localparam logic [63:0]        INV_F_E9     = 64'd298257223563;

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], n[k]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] mulsh_c(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int unsigned s);
    logic        neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] r;
    logic [127:0] p;
    neg = a[63] ^ b[63];
    ua  = a[63] ? (64'd0 - a) : a;
    ub  = b[63] ? (64'd0 - b) : b;
    p   = {64'd0, ua} * {64'd0, ub};
    p   = p + (128'd1 << (s - 1));
    p   = p >> s;
    r   = p[63:0];
    if (r[63]) r = 64'h7fff_ffff_ffff_ffff;
    return neg ? (64'd0 - r) : r;
  endfunction

  function automatic logic signed [63:0] inv_sqrt_c(input logic signed [63:0] v,
                                                    input logic signed [63:0] y0);
    logic signed [63:0] y;
    logic signed [63:0] t;
    y = y0;
    for (int i = 0; i < NEWTON; i++) begin
      t = mulsh_c(v, mulsh_c(y, y, 60), 60);
      y = mulsh_c(y, THREE - t, 61);
    end
    return y;
  endfunction

  function automatic logic [63:0] atan_inv(input logic [63:0] m);
    logic [63:0] p;
    logic [63:0] sum;
    p   = udiv(64'h4000_0000_0000_0000, m);
    sum = p;
    for (int n = 1; n < 40; n++) begin
      p = udiv(p, m * m);
      if (n % 2 == 1) sum = sum - udiv(p, 64'(2 * n + 1));
      else            sum = sum + udiv(p, 64'(2 * n + 1));
    end
    return sum;
  endfunction

  function automatic logic [63:0] calc_pi62();
    return 64'd16 * atan_inv(64'd5) - 64'd4 * atan_inv(64'd239);
  endfunction

  function automatic logic signed [63:0] calc_k_rad();
    logic [63:0] pi;
    logic [63:0] q1;
    logic [63:0] r1;
    pi = calc_pi62();
    q1 = udiv(pi, 64'd1800000000);
    r1 = pi - q1 * 64'd1800000000;
    return (q1 << 28) + udiv((r1 << 28) + 64'd900000000, 64'd1800000000);
  endfunction

  function automatic logic signed [63:0] atan_entry(input int i);
    logic signed [63:0] acc;
    logic [63:0]        t;
    int                 sh;
    acc = '0;
    if (i == 0) return calc_pi62() >> 4;
    for (int n = 0; n < 31; n++) begin
      sh = 60 - i * (2 * n + 1);
      if (sh >= 0) begin
        t   = udiv(64'd1 << sh, 64'(2 * n + 1));
        acc = (n % 2 == 1) ? acc - t : acc + t;
      end
    end
    return acc;
  endfunction

  function automatic logic signed [63:0] calc_k_gain();
    logic signed [63:0] p;
    p = ONE;
    for (int i = 0; i < ITER; i++) begin
      if (2 * i < 63) p = p + (p >>> (2 * i));
    end
    return inv_sqrt_c(p, udiv(ONE * 64'sd6, 64'd10));
  endfunction

  function automatic logic signed [63:0] calc_e2();
    logic [63:0] r;
    logic [63:0] f;
    r = 64'd1000000000;
    f = '0;
    for (int i = 0; i < 61; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= INV_F_E9) begin
        r    = r - INV_F_E9;
        f[0] = 1'b1;
      end
    end
    f = (f + 64'd1) >> 1;
    return 64'sd2 * f - mulsh_c(f, f, 60);
  endfunction

  localparam logic signed [63:0] K_RAD  = calc_k_rad();
  localparam logic signed [63:0] K_GAIN = calc_k_gain();
  localparam logic signed [63:0] E2_Q   = calc_e2();
  localparam logic signed [63:0] ONE_E2 = ONE - E2_Q;

endpackage

@@ hdl/g2e_dly.sv @@
// Enabled delay line for data that travels beside the arithmetic stages.
`timescale 1ns / 1ps
module g2e_dly #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 3
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);
  logic [Width-1:0] dq_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dq_q[0] <= d_i;
      for (int k = 1; k < Depth; k++) dq_q[k] <= dq_q[k-1];
    end
  end

  assign q_o = dq_q[Depth-1];
endmodule

@@ hdl/g2e_mul.sv @@
// Three-stage signed 64x64 multiply, rounded right shift and saturation.
`timescale 1ns / 1ps
module g2e_mul #(
  parameter int unsigned Shift = 60
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic signed [63:0] p_o
);
  localparam logic [127:0] RND = 128'd1 << (Shift - 1);

  logic        neg1_q, neg2_q;
  logic [63:0] ua_q, ub_q;
  logic [63:0] p00_q, p01_q, p10_q, p11_q;
  logic [127:0] sum;
  logic [63:0] r;
  logic signed [63:0] p_q;

  always_comb begin
    sum = {64'd0, p00_q} + ({64'd0, p01_q} << 32) + ({64'd0, p10_q} << 32)
        + {p11_q, 64'd0} + RND;
    r = sum[Shift+63:Shift];
    if (r[63]) r = 64'h7fff_ffff_ffff_ffff;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i[63] ^ b_i[63];
      ua_q   <= a_i[63] ? (64'd0 - a_i) : a_i;
      ub_q   <= b_i[63] ? (64'd0 - b_i) : b_i;
      neg2_q <= neg1_q;
      p00_q  <= ua_q[31:0] * ub_q[31:0];
      p01_q  <= ua_q[31:0] * ub_q[63:32];
      p10_q  <= ua_q[63:32] * ub_q[31:0];
      p11_q  <= ua_q[63:32] * ub_q[63:32];
      p_q    <= neg2_q ? (64'd0 - r) : r;
    end
  end

  assign p_o = p_q;
endmodule

@@ hdl/g2e_trig.sv @@
// Angle wrap and fold, radian scaling and pipelined rotation CORDIC.
`timescale 1ns / 1ps
module g2e_trig (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] ang_i,
  output logic signed [63:0] cos_o,
  output logic signed [63:0] sin_o
);
  localparam int unsigned M = g2e_pkg::MUL_LAT;
  localparam int unsigned N = g2e_pkg::ITER;

  logic signed [32:0] u_w, u_f;
  logic               flip;
  logic               flip_d;
  logic signed [63:0] z0;
  logic signed [63:0] x_q [N];
  logic signed [63:0] y_q [N];
  logic signed [63:0] z_q [N];

  always_comb begin
    u_w  = {ang_i[31], ang_i};
    flip = 1'b0;
    if (u_w > g2e_pkg::HALF_TURN) u_w = u_w - 33'sd2 * g2e_pkg::HALF_TURN;
    else if (u_w < -g2e_pkg::HALF_TURN) u_w = u_w + 33'sd2 * g2e_pkg::HALF_TURN;
    u_f = u_w;
    if (u_w > g2e_pkg::QUARTER_TURN) begin
      u_f  = g2e_pkg::HALF_TURN - u_w;
      flip = 1'b1;
    end else if (u_w < -g2e_pkg::QUARTER_TURN) begin
      u_f  = -g2e_pkg::HALF_TURN - u_w;
      flip = 1'b1;
    end
  end

  g2e_mul #(.Shift(30)) u_zmul (
    .clk_i, .en_i, .a_i({{31{u_f[32]}}, u_f}), .b_i(g2e_pkg::K_RAD), .p_o(z0)
  );

  g2e_dly #(.Width(1), .Depth(M + N)) u_flip (
    .clk_i, .en_i, .d_i(flip), .q_o(flip_d)
  );

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [63:0] ATAN = g2e_pkg::atan_entry(i);
    logic signed [63:0] xin, yin, zin;
    if (i == 0) begin : g_first
      assign xin = g2e_pkg::K_GAIN;
      assign yin = '0;
      assign zin = z0;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zin[63]) begin
          x_q[i] <= xin - (yin >>> i);
          y_q[i] <= yin + (xin >>> i);
          z_q[i] <= zin - ATAN;
        end else begin
          x_q[i] <= xin + (yin >>> i);
          y_q[i] <= yin - (xin >>> i);
          z_q[i] <= zin + ATAN;
        end
      end
    end
  end

  assign cos_o = flip_d ? (64'sd0 - x_q[N-1]) : x_q[N-1];
  assign sin_o = y_q[N-1];
endmodule

@@ hdl/g2e_ecef.sv @@
// Earth-centred position from trig values and altitude, with Newton inverse square root.
`timescale 1ns / 1ps
module g2e_ecef (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] clat_i,
  input  logic signed [63:0] slat_i,
  input  logic signed [63:0] clon_i,
  input  logic signed [63:0] slon_i,
  input  logic signed [63:0] hq_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic signed [63:0] z_o
);
  localparam int unsigned M  = g2e_pkg::MUL_LAT;
  localparam int unsigned NT = g2e_pkg::NEWTON;

  logic signed [63:0] s2, t, w;
  logic signed [63:0] y_v [NT+1];
  logic signed [63:0] w_v [NT+1];
  logic [319:0]       b0, b1;
  logic signed [63:0] n, rr, nb;
  logic signed [63:0] clat1, hq1, slat2, clon2, slon2, hq2;

  g2e_mul #(.Shift(60)) u_s2 (.clk_i, .en_i, .a_i(slat_i), .b_i(slat_i), .p_o(s2));
  g2e_mul #(.Shift(60)) u_t (.clk_i, .en_i, .a_i(g2e_pkg::E2_Q), .b_i(s2), .p_o(t));

  assign w      = g2e_pkg::ONE - t;
  assign y_v[0] = g2e_pkg::ONE;
  assign w_v[0] = w;

  for (genvar k = 0; k < NT; k++) begin : g_newton
    logic signed [63:0] yy, yd1, yd2, wd, t2;
    g2e_mul #(.Shift(60)) u_yy (.clk_i, .en_i, .a_i(y_v[k]), .b_i(y_v[k]), .p_o(yy));
    g2e_dly #(.Width(64), .Depth(M)) u_y1 (.clk_i, .en_i, .d_i(y_v[k]), .q_o(yd1));
    g2e_dly #(.Width(64), .Depth(M)) u_w1 (.clk_i, .en_i, .d_i(w_v[k]), .q_o(wd));
    g2e_mul #(.Shift(60)) u_t2 (.clk_i, .en_i, .a_i(wd), .b_i(yy), .p_o(t2));
    g2e_dly #(.Width(64), .Depth(M)) u_y2 (.clk_i, .en_i, .d_i(yd1), .q_o(yd2));
    g2e_mul #(.Shift(61)) u_yn (
      .clk_i, .en_i, .a_i(yd2), .b_i(g2e_pkg::THREE - t2), .p_o(y_v[k+1])
    );
    g2e_dly #(.Width(64), .Depth(2 * M)) u_w2 (.clk_i, .en_i, .d_i(wd), .q_o(w_v[k+1]));
  end

  g2e_dly #(.Width(320), .Depth((3 * NT + 3) * M)) u_b0 (
    .clk_i, .en_i, .d_i({clat_i, slat_i, clon_i, slon_i, hq_i}), .q_o(b0)
  );
  g2e_dly #(.Width(320), .Depth(M)) u_b1 (.clk_i, .en_i, .d_i(b0), .q_o(b1));

  assign clat1 = b0[319:256];
  assign hq1   = b0[63:0];
  assign slat2 = b1[255:192];
  assign clon2 = b1[191:128];
  assign slon2 = b1[127:64];
  assign hq2   = b1[63:0];

  g2e_mul #(.Shift(60)) u_n (.clk_i, .en_i, .a_i(g2e_pkg::A_Q16), .b_i(y_v[NT]), .p_o(n));
  g2e_mul #(.Shift(60)) u_rr (.clk_i, .en_i, .a_i(n + hq1), .b_i(clat1), .p_o(rr));
  g2e_mul #(.Shift(60)) u_nb (.clk_i, .en_i, .a_i(n), .b_i(g2e_pkg::ONE_E2), .p_o(nb));
  g2e_mul #(.Shift(60)) u_px (.clk_i, .en_i, .a_i(rr), .b_i(clon2), .p_o(x_o));
  g2e_mul #(.Shift(60)) u_py (.clk_i, .en_i, .a_i(rr), .b_i(slon2), .p_o(y_o));
  g2e_mul #(.Shift(60)) u_pz (.clk_i, .en_i, .a_i(nb + hq2), .b_i(slat2), .p_o(z_o));
endmodule

@@ hdl/g2e_enu.sv @@
// Rotate the earth-centred difference into the reference east-north-up frame.
`timescale 1ns / 1ps
module g2e_enu (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] rx_i,
  input  logic signed [63:0] ry_i,
  input  logic signed [63:0] rz_i,
  input  logic signed [63:0] tx_i,
  input  logic signed [63:0] ty_i,
  input  logic signed [63:0] tz_i,
  input  logic signed [63:0] clat_i,
  input  logic signed [63:0] slat_i,
  input  logic signed [63:0] clon_i,
  input  logic signed [63:0] slon_i,
  output logic signed [63:0] e_o,
  output logic signed [63:0] n_o,
  output logic signed [63:0] u_o
);
  localparam int unsigned M = g2e_pkg::MUL_LAT;

  logic signed [63:0] dx, dy, dz, dzd;
  logic signed [63:0] ma, mb, mc, md, e1, t1;
  logic signed [63:0] na, nb2, ua, ub;
  logic [127:0]       lat_d;

  assign dx = tx_i - rx_i;
  assign dy = ty_i - ry_i;
  assign dz = tz_i - rz_i;

  g2e_mul #(.Shift(60)) u_ma (.clk_i, .en_i, .a_i(dy), .b_i(clon_i), .p_o(ma));
  g2e_mul #(.Shift(60)) u_mb (.clk_i, .en_i, .a_i(dx), .b_i(slon_i), .p_o(mb));
  g2e_mul #(.Shift(60)) u_mc (.clk_i, .en_i, .a_i(dx), .b_i(clon_i), .p_o(mc));
  g2e_mul #(.Shift(60)) u_md (.clk_i, .en_i, .a_i(dy), .b_i(slon_i), .p_o(md));
  g2e_dly #(.Width(64), .Depth(M)) u_dz (.clk_i, .en_i, .d_i(dz), .q_o(dzd));
  g2e_dly #(.Width(128), .Depth(M)) u_lat (
    .clk_i, .en_i, .d_i({clat_i, slat_i}), .q_o(lat_d)
  );

  assign e1 = ma - mb;
  assign t1 = mc + md;

  g2e_mul #(.Shift(60)) u_na (.clk_i, .en_i, .a_i(dzd), .b_i(lat_d[127:64]), .p_o(na));
  g2e_mul #(.Shift(60)) u_nb (.clk_i, .en_i, .a_i(t1), .b_i(lat_d[63:0]), .p_o(nb2));
  g2e_mul #(.Shift(60)) u_ua (.clk_i, .en_i, .a_i(t1), .b_i(lat_d[127:64]), .p_o(ua));
  g2e_mul #(.Shift(60)) u_ub (.clk_i, .en_i, .a_i(dzd), .b_i(lat_d[63:0]), .p_o(ub));
  g2e_dly #(.Width(64), .Depth(M)) u_e (.clk_i, .en_i, .d_i(e1), .q_o(e_o));

  assign n_o = na - nb2;
  assign u_o = ua + ub;
endmodule

@@ hdl/geodetic_to_local_enu_top.sv @@
// Top level: WGS84 geodetic pair to local east-north-up offset, fully pipelined.
//
//   channel | signals                          | direction
//   input   | valid_i, ready_o, ref_*/target_* | in
//   output  | valid_o, ready_i, east/north/up  | out
//
// One word enters per cycle unless the output is held. Latency comes from the
// 60-stage CORDIC and the three-stage multipliers, most in the Newton step.
// Reset clears only the valid bits. When the output word is held, the whole
// pipeline freezes; no word is dropped or repeated.
`timescale 1ns / 1ps
module geodetic_to_local_enu_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [30:0] ref_latitude_i,
  input  logic signed [31:0] ref_longitude_i,
  input  logic signed [27:0] ref_altitude_i,
  input  logic signed [30:0] target_latitude_i,
  input  logic signed [31:0] target_longitude_i,
  input  logic signed [27:0] target_altitude_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [35:0] east_o,
  output logic signed [35:0] north_o,
  output logic signed [35:0] up_o,
  output logic               overflow_o
);
  localparam int unsigned M   = g2e_pkg::MUL_LAT;
  localparam int unsigned LAT = 32 * M + g2e_pkg::ITER + 1;

  logic               en;
  logic [LAT-1:0]     vld_q;
  logic signed [63:0] rcl, rsl, rco, rso, tcl, tsl, tco, tso;
  logic signed [63:0] rhq, thq, rhq_d, thq_d;
  logic signed [63:0] rx, ry, rz, tx, ty, tz;
  logic [255:0]       rtrig_d;
  logic signed [63:0] e, n, u;
  logic signed [63:0] er, nr, ur;
  logic               oe, on, ou;
  logic signed [35:0] east_q, north_q, up_q;
  logic               ovf_q;

  assign en      = !vld_q[LAT-1] || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  g2e_trig u_rlat (.clk_i, .en_i(en), .ang_i({ref_latitude_i[30], ref_latitude_i}),
                   .cos_o(rcl), .sin_o(rsl));
  g2e_trig u_rlon (.clk_i, .en_i(en), .ang_i(ref_longitude_i), .cos_o(rco), .sin_o(rso));
  g2e_trig u_tlat (.clk_i, .en_i(en),
                   .ang_i({target_latitude_i[30], target_latitude_i}),
                   .cos_o(tcl), .sin_o(tsl));
  g2e_trig u_tlon (.clk_i, .en_i(en), .ang_i(target_longitude_i), .cos_o(tco), .sin_o(tso));

  assign rhq = {{20{ref_altitude_i[27]}}, ref_altitude_i, 16'd0};
  assign thq = {{20{target_altitude_i[27]}}, target_altitude_i, 16'd0};

  g2e_dly #(.Width(64), .Depth(M + g2e_pkg::ITER)) u_rh (
    .clk_i, .en_i(en), .d_i(rhq), .q_o(rhq_d)
  );
  g2e_dly #(.Width(64), .Depth(M + g2e_pkg::ITER)) u_th (
    .clk_i, .en_i(en), .d_i(thq), .q_o(thq_d)
  );

  g2e_ecef u_recef (.clk_i, .en_i(en), .clat_i(rcl), .slat_i(rsl), .clon_i(rco),
                    .slon_i(rso), .hq_i(rhq_d), .x_o(rx), .y_o(ry), .z_o(rz));
  g2e_ecef u_tecef (.clk_i, .en_i(en), .clat_i(tcl), .slat_i(tsl), .clon_i(tco),
                    .slon_i(tso), .hq_i(thq_d), .x_o(tx), .y_o(ty), .z_o(tz));

  g2e_dly #(.Width(256), .Depth(29 * M)) u_rtrig (
    .clk_i, .en_i(en), .d_i({rcl, rsl, rco, rso}), .q_o(rtrig_d)
  );

  g2e_enu u_enu (
    .clk_i, .en_i(en),
    .rx_i(rx), .ry_i(ry), .rz_i(rz), .tx_i(tx), .ty_i(ty), .tz_i(tz),
    .clat_i(rtrig_d[255:192]), .slat_i(rtrig_d[191:128]),
    .clon_i(rtrig_d[127:64]), .slon_i(rtrig_d[63:0]),
    .e_o(e), .n_o(n), .u_o(u)
  );

  always_comb begin
    er = (e + 64'sd32768) >>> 16;
    nr = (n + 64'sd32768) >>> 16;
    ur = (u + 64'sd32768) >>> 16;
    oe = 1'b0;
    on = 1'b0;
    ou = 1'b0;
    if (er > g2e_pkg::OUT_LIM) begin
      er = g2e_pkg::OUT_LIM;
      oe = 1'b1;
    end else if (er < -g2e_pkg::OUT_LIM) begin
      er = -g2e_pkg::OUT_LIM;
      oe = 1'b1;
    end
    if (nr > g2e_pkg::OUT_LIM) begin
      nr = g2e_pkg::OUT_LIM;
      on = 1'b1;
    end else if (nr < -g2e_pkg::OUT_LIM) begin
      nr = -g2e_pkg::OUT_LIM;
      on = 1'b1;
    end
    if (ur > g2e_pkg::OUT_LIM) begin
      ur = g2e_pkg::OUT_LIM;
      ou = 1'b1;
    end else if (ur < -g2e_pkg::OUT_LIM) begin
      ur = -g2e_pkg::OUT_LIM;
      ou = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      east_q  <= er[35:0];
      north_q <= nr[35:0];
      up_q    <= ur[35:0];
      ovf_q   <= oe | on | ou;
    end
  end

  assign valid_o    = vld_q[LAT-1];
  assign east_o     = east_q;
  assign north_o    = north_q;
  assign up_o       = up_q;
  assign overflow_o = ovf_q;
endmodule

@@ test/geodetic_to_local_enu_top_tb.sv @@
// Self-checking testbench for geodetic_to_local_enu_top: predicts ENU offsets in fixed point.
`timescale 1ns / 1ps
module geodetic_to_local_enu_top_tb;

  typedef struct {
    logic signed [35:0] east;
    logic signed [35:0] north;
    logic signed [35:0] up;
    logic               overflow;
  } enu_offset_t;

  class enu_scoreboard;
    longint      atan_q60[60];
    longint      deg_to_rad_q90;
    longint      cordic_comp;
    longint      ecc2;
    enu_offset_t expected_offsets[$];
    int          mismatches;
    int          checked;

    function new();
      longint unsigned pi62, q1, r1, d, r, f;
      longint          p, acc, t;
      pi62 = 16 * arctan_recip(5) - 4 * arctan_recip(239);
      d = 64'd1800000000;
      q1 = pi62 / d;
      r1 = pi62 % d;
      deg_to_rad_q90 = longint'((q1 << 28) + ((r1 << 28) + d / 2) / d);
      atan_q60[0] = longint'(pi62 >> 4);
      for (int i = 1; i < 60; i++) begin
        acc = 0;
        for (int n = 0; 60 - i * (2 * n + 1) >= 0; n++) begin
          t = (64'sd1 <<< (60 - i * (2 * n + 1))) / longint'(2 * n + 1);
          acc = (n % 2 == 1) ? acc - t : acc + t;
        end
        atan_q60[i] = acc;
      end
      p = 64'sd1 <<< 60;
      for (int i = 0; i < 60; i++) if (2 * i < 63) p = p + (p >>> (2 * i));
      cordic_comp = rsqrt(p, (64'sd1 <<< 60) * 6 / 10);
      r = 64'd1000000000;
      f = 0;
      for (int i = 0; i < 61; i++) begin
        r = r << 1;
        f = f << 1;
        if (r >= 64'd298257223563) begin
          r = r - 64'd298257223563;
          f = f | 64'd1;
        end
      end
      f = (f + 1) >> 1;
      ecc2 = 2 * longint'(f) - mul_round(longint'(f), longint'(f), 60);
      mismatches = 0;
      checked = 0;
    endfunction

    function longint mul_round(longint a, longint b, int s);
      logic              neg;
      longint unsigned   ua, ub, res;
      logic [127:0]      prod;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'd0 - longint'(a) : a;
      ub = (b < 0) ? 64'd0 - longint'(b) : b;
      prod = {64'd0, ua} * {64'd0, ub};
      prod = prod + (128'd1 << (s - 1));
      res = prod[s +: 64];
      if (res[63]) res = 64'h7fff_ffff_ffff_ffff;
      return neg ? -longint'(res) : longint'(res);
    endfunction

    function longint rsqrt(longint v, longint y);
      longint t;
      for (int i = 0; i < 8; i++) begin
        t = mul_round(v, mul_round(y, y, 60), 60);
        y = mul_round(y, (64'sd3 <<< 60) - t, 61);
      end
      return y;
    endfunction

    function longint unsigned arctan_recip(longint unsigned m);
      longint unsigned p, sum;
      p = (64'd1 << 62) / m;
      sum = p;
      for (int n = 1; n < 40; n++) begin
        p = p / (m * m);
        if (n % 2 == 1) sum = sum - p / (2 * n + 1);
        else sum = sum + p / (2 * n + 1);
      end
      return sum;
    endfunction

    function void cos_sin(longint u, output longint c, output longint s);
      logic   flip;
      longint x, y, z, dx, dy;
      flip = 0;
      x = cordic_comp;
      y = 0;
      if (u > 64'sd1800000000) u = u - 64'sd3600000000;
      else if (u < -64'sd1800000000) u = u + 64'sd3600000000;
      if (u > 64'sd900000000) begin
        u = 64'sd1800000000 - u;
        flip = 1;
      end else if (u < -64'sd900000000) begin
        u = -64'sd1800000000 - u;
        flip = 1;
      end
      z = mul_round(u, deg_to_rad_q90, 30);
      for (int i = 0; i < 60; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - atan_q60[i];
        end else begin
          x = x + dx; y = y - dy; z = z + atan_q60[i];
        end
      end
      c = flip ? -x : x;
      s = y;
    endfunction

    function void earth_centred(longint lat, longint lon, longint h,
                                output longint pos[3], output longint tv[4]);
      longint w, n, rr, hq, one;
      one = 64'sd1 <<< 60;
      hq = h * 65536;
      cos_sin(lat, tv[0], tv[1]);
      cos_sin(lon, tv[2], tv[3]);
      w = one - mul_round(ecc2, mul_round(tv[1], tv[1], 60), 60);
      n = mul_round(64'sd6378137000 * 65536, rsqrt(w, one), 60);
      rr = mul_round(n + hq, tv[0], 60);
      pos[0] = mul_round(rr, tv[2], 60);
      pos[1] = mul_round(rr, tv[3], 60);
      pos[2] = mul_round(mul_round(n, one - ecc2, 60) + hq, tv[1], 60);
    endfunction

    function logic signed [35:0] to_mm(longint q16, inout logic ovf);
      longint r;
      r = (q16 + 32768) >>> 16;
      if (r > 64'sd20000000000) begin
        r = 64'sd20000000000; ovf = 1;
      end else if (r < -64'sd20000000000) begin
        r = -64'sd20000000000; ovf = 1;
      end
      return r[35:0];
    endfunction

    function void note_point_pair(longint rlat, longint rlon, longint ralt,
                                  longint tlat, longint tlon, longint talt);
      longint      pr[3], pt[3], tr[4], tt[4], dx, dy, dz, t, e, nn, uu;
      enu_offset_t exp_off;
      earth_centred(rlat, rlon, ralt, pr, tr);
      earth_centred(tlat, tlon, talt, pt, tt);
      dx = pt[0] - pr[0];
      dy = pt[1] - pr[1];
      dz = pt[2] - pr[2];
      e  = mul_round(dy, tr[2], 60) - mul_round(dx, tr[3], 60);
      t  = mul_round(dx, tr[2], 60) + mul_round(dy, tr[3], 60);
      nn = mul_round(dz, tr[0], 60) - mul_round(t, tr[1], 60);
      uu = mul_round(t, tr[0], 60) + mul_round(dz, tr[1], 60);
      exp_off.overflow = 0;
      exp_off.east  = to_mm(e, exp_off.overflow);
      exp_off.north = to_mm(nn, exp_off.overflow);
      exp_off.up    = to_mm(uu, exp_off.overflow);
      expected_offsets.insert(expected_offsets.size(), exp_off);
    endfunction

    function void check_offset(enu_offset_t got);
      enu_offset_t exp_off;
      checked++;
      if (expected_offsets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: east %0d north %0d up %0d",
                                       got.east, got.north, got.up);
        return;
      end
      exp_off = expected_offsets.pop_front();
      if (got.east !== exp_off.east || got.north !== exp_off.north ||
          got.up !== exp_off.up || got.overflow !== exp_off.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: exp %0d %0d %0d ovf %0b, got %0d %0d %0d ovf %0b",
                   checked, exp_off.east, exp_off.north, exp_off.up, exp_off.overflow,
                   got.east, got.north, got.up, got.overflow);
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               valid_i = 0;
  logic               ready_o;
  logic signed [30:0] ref_latitude_i = '0;
  logic signed [31:0] ref_longitude_i = '0;
  logic signed [27:0] ref_altitude_i = '0;
  logic signed [30:0] target_latitude_i = '0;
  logic signed [31:0] target_longitude_i = '0;
  logic signed [27:0] target_altitude_i = '0;
  logic               valid_o;
  logic               ready_i = 0;
  logic signed [35:0] east_o;
  logic signed [35:0] north_o;
  logic signed [35:0] up_o;
  logic               overflow_o;

  enu_scoreboard sb;
  int            send_idle = 36;
  int            recv_idle = 73;
  bit            long_hold_req = 0;
  int            hold_left = 0;
  longint        cycles = 0;
  int            sent = 0;

  geodetic_to_local_enu_top i_dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("geodetic_to_local_enu_top verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (valid_i && ready_o)
        sb.note_point_pair(ref_latitude_i, ref_longitude_i, ref_altitude_i,
                           target_latitude_i, target_longitude_i, target_altitude_i);
      if (valid_o && ready_i)
        sb.check_offset('{east_o, north_o, up_o, overflow_o});
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      ready_i <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      ready_i <= 0;
    end else if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = 400;
      ready_i <= 0;
    end else begin
      ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_pair(longint rlat, longint rlon, longint ralt,
                           longint tlat, longint tlon, longint talt);
    while ($urandom_range(99) < send_idle) begin
      valid_i <= 0;
      @(negedge clk_i);
    end
    valid_i            <= 1;
    ref_latitude_i     <= rlat[30:0];
    ref_longitude_i    <= rlon[31:0];
    ref_altitude_i     <= ralt[27:0];
    target_latitude_i  <= tlat[30:0];
    target_longitude_i <= tlon[31:0];
    target_altitude_i  <= talt[27:0];
    do @(posedge clk_i); while (!(valid_i && ready_o));
    @(negedge clk_i);
    sent++;
  endtask

  task automatic drain();
    valid_i <= 0;
    @(negedge clk_i);
    while (sb.expected_offsets.size() != 0) @(negedge clk_i);
  endtask

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  task automatic send_random();
    longint rlat, rlon, ralt, tlat, tlon, talt;
    int     mode;
    mode = $urandom_range(99);
    if (mode < 20) begin
      rlat = longint'($signed(31'($urandom())));
      rlon = longint'($signed($urandom()));
      ralt = longint'($signed(28'($urandom())));
      tlat = longint'($signed(31'($urandom())));
      tlon = longint'($signed($urandom()));
      talt = longint'($signed(28'($urandom())));
    end else begin
      rlat = pick(-900000000, 900000000);
      rlon = pick(-1800000000, 1800000000);
      ralt = pick(-1000000, 100000000);
      if (mode < 50) begin
        tlat = pick(-900000000, 900000000);
        tlon = pick(-1800000000, 1800000000);
        talt = pick(-1000000, 100000000);
      end else begin
        tlat = rlat + pick(-1000000, 1000000);
        tlon = rlon + pick(-1000000, 1000000);
        talt = ralt + pick(-1000000, 1000000);
      end
    end
    send_pair(rlat, rlon, ralt, tlat, tlon, talt);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 1);
    send_pair(900000000, 0, 0, -900000000, 0, 0);
    send_pair(-900000000, 1800000000, 100000000, 900000000, -1800000000, -1000000);
    send_pair(0, 0, 0, 0, 1800000000, 0);
    send_pair(0, -1800000000, -1000000, 0, 0, 100000000);
    send_pair(-1073741824, 0, 0, 1073741823, 0, 0);
    send_pair(1000000000, -64'sd2147483648, -134217728, -1000000000, 2147483647, 134217727);
    send_pair(0, 2147483647, 134217727, 0, -64'sd2147483648, -134217728);
    send_pair(1073741823, 1900000000, 0, -1073741824, -1900000000, 0);
    send_pair(450000000, 900000000, 5000, 450000001, 900000001, 5001);
    send_pair(-450000000, -900000000, 0, -449999999, -900000000, -1);
    send_pair(899999999, 1799999999, 0, 900000000, 1800000000, 0);
    send_pair(-1, -1, -1, 1, 1, 1);
    send_pair(515000000, -1200000, 45000, 515100000, -1100000, 46000);
    send_pair(0, 0, 0, 0, 0, 0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 36 : (phase == 1) ? 73 : 0;
      recv_idle = (phase == 0) ? 73 : (phase == 1) ? 36 : 0;
      for (int k = 0; k < 460; k++) begin
        if (k == 100 && phase != 1) long_hold_req = 1;
        if (k == 300) drain();
        send_random();
      end
    end

    valid_i <= 0;
    while (sb.expected_offsets.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("%0d coordinate pairs sent (poles, antimeridian, field extremes, local and global",
             sent);
    $display("pairs), %0d offsets checked under three idling patterns and long output holds",
             sb.checked);
    if (sb.mismatches == 0 && sb.expected_offsets.size() == 0) begin
      $display("geodetic_to_local_enu_top verification clean");
    end else begin
      $display("geodetic_to_local_enu_top verification failed");
    end
    $finish;
  end

endmodule
